FILE: hw/rtl/sdc_pkg.sv
`timescale 1ns / 1ps
package sdc_pkg;

   // ring geometry and generator taps (x^16 + x^12 + x^5 + 1)
   localparam int RING_LEN  = 16;
   localparam int TAP_A     = 12;
   localparam int TAP_B     = 5;
   localparam int CRC_BYTES = 8;

   // configuration register indexes and field values
   localparam int BLOCK_BYTES_W = 13;
   localparam logic [0:0] REG_MODE        = 1'b0;
   localparam logic [0:0] REG_BLOCK_BYTES = 1'b1;
   localparam logic MODE_CHECK = 1'b0;
   localparam logic MODE_GEN   = 1'b1;
   localparam logic [BLOCK_BYTES_W-1:0] BLOCK_BYTES_RESET = 13'd512;

   typedef logic [3:0] nib_type;
   typedef logic [7:0] byte_type;

   // ring operation for one cycle
   typedef struct packed {
      logic pre_clr;
      logic feed;
      logic pop;
      logic post_clr;
   } ring_ctl_type;

   // result load into the output buffer
   typedef struct packed {
      logic load;
      logic burst;
      logic mismatch;
      logic bad;
      logic last;
   } load_ctl_type;

   // output buffer fill status
   typedef struct packed {
      logic empty;
      logic one_left;
   } obuf_stat_type;

endpackage

FILE: hw/rtl/sdc_req_if.sv
`timescale 1ns / 1ps
interface sdc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_block;

   modport source (output valid, data_byte, start_block, input ready);
   modport sink   (input valid, data_byte, start_block, output ready);
endinterface

FILE: hw/rtl/sdc_rsp_if.sv
`timescale 1ns / 1ps
interface sdc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] crc_byte;
   logic       crc_mismatch;
   logic       block_bad;
   logic       last;

   modport source (output valid, crc_byte, crc_mismatch, block_bad, last, input ready);
   modport sink   (input valid, crc_byte, crc_mismatch, block_bad, last, output ready);
endinterface

FILE: hw/rtl/sdc_cell.sv
`timescale 1ns / 1ps
module sdc_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             pre_clr,
   input  logic             post_clr,
   input  sdc_pkg::nib_type up_nib,
   input  sdc_pkg::nib_type tap_nib,
   output sdc_pkg::nib_type q,
   output sdc_pkg::nib_type shift_nib
);

   sdc_pkg::nib_type q_ff;
   sdc_pkg::nib_type q_in;

   // take the neighbor's nibble, folded with the feedback tap
   assign shift_nib = up_nib ^ tap_nib;
   assign q         = q_ff;

   // select next nibble: clear after block, advance, clear before item, or hold
   always_comb begin
      if (post_clr) begin
         q_in = '0;
      end else if (adv) begin
         q_in = shift_nib;
      end else if (pre_clr) begin
         q_in = '0;
      end else begin
         q_in = q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff <= '0;
      end else begin
         q_ff <= q_in;
      end
   end

endmodule

FILE: hw/rtl/sdc_ring.sv
`timescale 1ns / 1ps
module sdc_ring (
   input  logic                                         clock,
   input  logic                                         reset,
   input  sdc_pkg::ring_ctl_type                        ctl,
   input  sdc_pkg::nib_type                             hi_nib,
   input  sdc_pkg::nib_type                             lo_nib,
   output sdc_pkg::byte_type                            head_byte,
   output sdc_pkg::nib_type [sdc_pkg::RING_LEN-1:0]     snap
);

   // cell index of each tap, oldest stage at index 0
   localparam int POS_A = sdc_pkg::RING_LEN - sdc_pkg::TAP_A;
   localparam int POS_B = sdc_pkg::RING_LEN - sdc_pkg::TAP_B;

   sdc_pkg::nib_type [sdc_pkg::RING_LEN-1:0] q;
   sdc_pkg::nib_type [sdc_pkg::RING_LEN-1:0] cur;
   sdc_pkg::nib_type [sdc_pkg::RING_LEN-1:0] tap;
   sdc_pkg::nib_type                         fb1;
   sdc_pkg::nib_type                         fb2;
   logic                                     adv;

   assign adv = ctl.feed | ctl.pop;

   // view of the ring with a block start already applied
   assign cur = ctl.pre_clr ? '0 : q;

   // feedback of the high nibble step, then of the low nibble step
   assign fb1 = cur[0] ^ hi_nib;
   assign fb2 = cur[1] ^ lo_nib;

   assign head_byte = {cur[0], cur[1]};

   genvar j;
   generate
      for (j = 0; j < sdc_pkg::RING_LEN; j++) begin : g_cell
         // fold feedback into the cells fed by the tap stages
         always_comb begin
            tap[j] = '0;
            if (ctl.feed) begin
               if (j == sdc_pkg::RING_LEN - 2) begin
                  tap[j] = hi_nib;
               end else if (j == sdc_pkg::RING_LEN - 1) begin
                  tap[j] = lo_nib;
               end else if (j == POS_A - 2 || j == POS_B - 2) begin
                  tap[j] = fb1;
               end else if (j == POS_A - 1 || j == POS_B - 1) begin
                  tap[j] = fb2;
               end
            end
         end

         sdc_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .adv       (adv),
            .pre_clr   (ctl.pre_clr),
            .post_clr  (ctl.post_clr),
            .up_nib    (cur[(j + 2) % sdc_pkg::RING_LEN]),
            .tap_nib   (tap[j]),
            .q         (q[j]),
            .shift_nib (snap[j])
         );
      end
   endgenerate

endmodule

FILE: hw/rtl/sdc_obuf.sv
`timescale 1ns / 1ps
module sdc_obuf (
   input  logic                                          clock,
   input  logic                                          reset,
   input  sdc_pkg::load_ctl_type                         ld,
   input  sdc_pkg::byte_type [sdc_pkg::CRC_BYTES-1:0]    ld_bytes,
   output sdc_pkg::obuf_stat_type                        stat,
   sdc_rsp_if.source                                     rsp_ch
);

   localparam int N     = sdc_pkg::CRC_BYTES;
   localparam int CNT_W = $clog2(N + 1);

   sdc_pkg::byte_type [N-1:0] data_ff;
   sdc_pkg::byte_type [N-1:0] data_in;
   logic [N-1:0]              last_ff;
   logic [N-1:0]              last_in;
   logic [CNT_W-1:0]          cnt_ff;
   logic [CNT_W-1:0]          cnt_in;
   logic                      mis_ff;
   logic                      mis_in;
   logic                      bad_ff;
   logic                      bad_in;
   logic                      pop;

   assign pop = rsp_ch.valid & rsp_ch.ready;

   // load a new result set, or advance the line by one item
   always_comb begin
      data_in = data_ff;
      last_in = last_ff;
      cnt_in  = cnt_ff;
      mis_in  = mis_ff;
      bad_in  = bad_ff;
      if (ld.load) begin
         data_in = ld_bytes;
         mis_in  = ld.mismatch;
         bad_in  = ld.bad;
         last_in = '0;
         if (ld.burst) begin
            cnt_in       = CNT_W'(N);
            last_in[N-1] = 1'b1;
         end else begin
            cnt_in     = CNT_W'(1);
            last_in[0] = ld.last;
         end
      end else if (pop) begin
         for (int i = 0; i < N - 1; i++) begin
            data_in[i] = data_ff[i + 1];
            last_in[i] = last_ff[i + 1];
         end
         last_in[N-1] = 1'b0;
         cnt_in       = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
      mis_ff  <= mis_in;
      bad_ff  <= bad_in;
   end

   // drive the head item
   assign rsp_ch.valid        = (cnt_ff != '0);
   assign rsp_ch.crc_byte     = data_ff[0];
   assign rsp_ch.crc_mismatch = mis_ff;
   assign rsp_ch.block_bad    = bad_ff;
   assign rsp_ch.last         = last_ff[0];

   assign stat.empty    = (cnt_ff == '0);
   assign stat.one_left = (cnt_ff == CNT_W'(1));

   a_load_room: assert property (@(posedge clock) disable iff (reset)
      ld.load |-> (cnt_ff == '0 || (cnt_ff == CNT_W'(1) && pop)))
      else $error("result load while output line still holds items");

   a_last_at_end: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0 && last_ff[0]) |-> cnt_ff == CNT_W'(1))
      else $error("last item at head with more items behind it");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(N))
      else $error("output line count out of range");

endmodule

FILE: hw/rtl/sd_four_lane_data_crc16.sv
`timescale 1ns / 1ps
// A result item is presented in the cycle after the item that caused it is accepted.
// One item per cycle while ready is high; the check-mode CRC bytes give one result each.
// A generate-mode block end loads 8 CRC items at once, drained one per cycle while
// rsp_ch.ready is high; a block-ending item waits until the output line is nearly empty.
// Reset (synchronous): clears ring, counter and bad flag; mode = check, block_bytes = 512.
module sd_four_lane_data_crc16 #(
   parameter int MAX_BLOCK_BYTES = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [0:0]                        csr_index,
   input  logic [sdc_pkg::BLOCK_BYTES_W-1:0] csr_wdata,
   sdc_req_if.sink                           req_ch,
   sdc_rsp_if.source                         rsp_ch
);

   localparam int CW = $clog2(MAX_BLOCK_BYTES + sdc_pkg::CRC_BYTES);
   localparam int LW = (CW > sdc_pkg::BLOCK_BYTES_W) ? CW : sdc_pkg::BLOCK_BYTES_W;

   logic                              mode_ff;
   logic                              mode_in;
   logic [sdc_pkg::BLOCK_BYTES_W-1:0] blk_ff;
   logic [sdc_pkg::BLOCK_BYTES_W-1:0] blk_in;
   logic [CW-1:0]                     cnt_ff;
   logic [CW-1:0]                     cnt_in;
   logic                              bad_ff;
   logic                              bad_in;

   logic [LW-1:0]                     len_w;
   logic [CW-1:0]                     len;
   logic [CW-1:0]                     cnt0;
   logic [CW-1:0]                     cnt1;
   logic [CW-1:0]                     idx;
   logic                              bad0;
   logic                              badn;
   logic                              mis;
   logic                              pre;
   logic                              may_emit;
   logic                              acc;

   sdc_pkg::ring_ctl_type                        rctl;
   sdc_pkg::load_ctl_type                        ld;
   sdc_pkg::obuf_stat_type                       stat;
   sdc_pkg::byte_type                            head_byte;
   sdc_pkg::nib_type [sdc_pkg::RING_LEN-1:0]     snap;
   sdc_pkg::byte_type [sdc_pkg::CRC_BYTES-1:0]   ld_bytes;

   // write configuration registers
   always_comb begin
      mode_in = mode_ff;
      blk_in  = blk_ff;
      if (csr_we) begin
         case (csr_index)
            sdc_pkg::REG_MODE:        mode_in = csr_wdata[0];
            sdc_pkg::REG_BLOCK_BYTES: blk_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= sdc_pkg::MODE_CHECK;
         blk_ff  <= sdc_pkg::BLOCK_BYTES_RESET;
      end else begin
         mode_ff <= mode_in;
         blk_ff  <= blk_in;
      end
   end

   // clamp block length to one .. MAX_BLOCK_BYTES
   always_comb begin
      len_w = LW'(blk_ff);
      if (len_w == '0) begin
         len_w = LW'(1);
      end
      if (len_w > LW'(MAX_BLOCK_BYTES)) begin
         len_w = LW'(MAX_BLOCK_BYTES);
      end
      len = len_w[CW-1:0];
   end

   // hold off input only when the next item could load results into a busy line
   always_comb begin
      if (mode_ff == sdc_pkg::MODE_GEN) begin
         may_emit = (len == CW'(1)) || (cnt_ff == len - CW'(1));
      end else begin
         may_emit = (cnt_ff >= len);
      end
   end

   assign req_ch.ready = stat.empty | (stat.one_left & rsp_ch.ready) | ~may_emit;
   assign acc          = req_ch.valid & req_ch.ready;

   // sequence one item: block restart, data feed or CRC compare, block end
   always_comb begin
      cnt0 = req_ch.start_block ? '0 : cnt_ff;
      bad0 = req_ch.start_block ? 1'b0 : bad_ff;
      pre  = req_ch.start_block;
      if (mode_ff == sdc_pkg::MODE_GEN && cnt0 >= len) begin
         cnt0 = '0;
         bad0 = 1'b0;
         pre  = 1'b1;
      end
      cnt1   = cnt0 + CW'(1);
      idx    = cnt0 - len;
      mis    = (head_byte != req_ch.data_byte);
      badn   = bad0 | mis;
      rctl   = '0;
      ld     = '0;
      cnt_in = cnt_ff;
      bad_in = bad_ff;
      if (acc) begin
         rctl.pre_clr = pre;
         if (cnt0 < len) begin
            rctl.feed = 1'b1;
            if (mode_ff == sdc_pkg::MODE_GEN && cnt1 == len) begin
               ld.load       = 1'b1;
               ld.burst      = 1'b1;
               rctl.post_clr = 1'b1;
               cnt_in        = '0;
               bad_in        = 1'b0;
            end else begin
               cnt_in = cnt1;
               bad_in = bad0;
            end
         end else begin
            rctl.pop    = 1'b1;
            ld.load     = 1'b1;
            ld.mismatch = mis;
            if (idx >= CW'(sdc_pkg::CRC_BYTES - 1)) begin
               ld.bad        = badn;
               ld.last       = 1'b1;
               rctl.post_clr = 1'b1;
               cnt_in        = '0;
               bad_in        = 1'b0;
            end else begin
               cnt_in = cnt1;
               bad_in = badn;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         bad_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         bad_ff <= bad_in;
      end
   end

   // pack the ring into CRC bytes, high nibble first; single results use the head
   always_comb begin
      for (int k = 0; k < sdc_pkg::CRC_BYTES; k++) begin
         ld_bytes[k] = {snap[2 * k], snap[2 * k + 1]};
      end
      if (!ld.burst) begin
         ld_bytes[0] = head_byte;
      end
   end

   sdc_ring u_ring (
      .clock     (clock),
      .reset     (reset),
      .ctl       (rctl),
      .hi_nib    (req_ch.data_byte[7:4]),
      .lo_nib    (req_ch.data_byte[3:0]),
      .head_byte (head_byte),
      .snap      (snap)
   );

   sdc_obuf u_obuf (
      .clock    (clock),
      .reset    (reset),
      .ld       (ld),
      .ld_bytes (ld_bytes),
      .stat     (stat),
      .rsp_ch   (rsp_ch)
   );

   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      ld.load |=> rsp_ch.valid)
      else $error("loaded result not presented");

   a_block_end_clears: assert property (@(posedge clock) disable iff (reset)
      rctl.post_clr |=> (cnt_ff == '0 && !bad_ff))
      else $error("counter or bad flag not cleared at block end");

   a_crc_phase_runs: assert property (@(posedge clock) disable iff (reset)
      (ld.load && !ld.burst && !ld.last) |=> cnt_ff != '0)
      else $error("CRC phase counter lost before last CRC byte");

endmodule
